// ===== src/dtq_pkg.sv =====
// Package for the deadline timer queue.
// Holds the request and status codes and the fixed field widths.
// Used by deadline_timer_queue; depends on nothing.
`default_nettype none

package dtq_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned OUT_ID_W  = 8;
  localparam int unsigned CANCEL_W  = 8;

  // Most entries that one tick may fire.
  localparam int unsigned MAX_RESULTS = 16;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_STOP   = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED         = 3'd0,
    ST_FULL          = 3'd1,
    ST_NOT_ACCEPTING = 3'd2,
    ST_CANCELLED     = 3'd3,
    ST_CANCEL_FAILED = 3'd4,
    ST_FIRED         = 3'd5,
    ST_NONE_DUE      = 3'd6,
    ST_STOPPED       = 3'd7
  } status_e;

endpackage

`default_nettype wire

// ===== src/dtq_entry_ram.sv =====
// Entry store of the deadline timer queue: one write port and one
// registered read port. Depends on nothing.
`default_nettype none

module dtq_entry_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 40
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/deadline_timer_queue.sv =====
// Deadline timer queue: a sorted list of pending deadlines with add,
// cancel, tick and stop requests. Depends on dtq_pkg and dtq_entry_ram.
//
// Usage: a request (req_type_i with due_time_i, cancel_id_i or now_time_i)
// is taken when in_valid_i and in_ready_o are both high. Each request gives
// one or more results (status_o, item_id_o, last_o) on the output channel;
// last_o marks the final result of the request. The entries sit in a memory
// with one write port and one read port, walked by a small sequencer, so
// in_ready_o stays low while a request is being worked on.
// Work per request, with N stored entries:
//   stop, or add/tick after stop, or add to a full queue: answered from idle.
//   cancel: a walk over all N entries.
//   add: a walk over up to N entries per id tried in the free id search,
//     then the ordered insert, which walks down from the tail.
//   tick firing K entries: reads from the head, then moves the other N - K
//     entries down to close the gap left at the head of the queue.
// Results leave through an output register. A new request is taken only
// once that register is free, so a result that waits on the receiver holds
// the request side off; when the receiver stalls the sequencer also waits
// before each further result.
// Reset empties the queue, sets the next id to zero and allows adds; the
// memory needs no clearing, as only entries below the count are read.
`default_nettype none

module deadline_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  parameter int unsigned TIME_BITS   = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dtq_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [TIME_BITS-1:0]          due_time_i,
  input  wire logic [dtq_pkg::CANCEL_W-1:0]  cancel_id_i,
  input  wire logic [TIME_BITS-1:0]          now_time_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [dtq_pkg::STATUS_W-1:0]  status_o,
  output logic      [dtq_pkg::OUT_ID_W-1:0]  item_id_o,
  output logic                               last_o
);

  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned ENT_W  = TIME_BITS + ID_BITS;
  localparam int unsigned CMP_W  = (ID_BITS > dtq_pkg::CANCEL_W) ? ID_BITS : dtq_pkg::CANCEL_W;
  localparam int unsigned FIRE_LIMIT =
    (QUEUE_DEPTH < dtq_pkg::MAX_RESULTS) ? QUEUE_DEPTH : dtq_pkg::MAX_RESULTS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ID_RD,
    S_ID_CHK,
    S_INS_RD,
    S_INS_CHK,
    S_CAN_RD,
    S_CAN_CHK,
    S_TICK_RD,
    S_TICK_CHK,
    S_TICK_END,
    S_CMP_RD,
    S_CMP_WR,
    S_FIN
  } state_e;

  state_e                        state_q, state_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [ID_BITS-1:0]            next_id_q, next_id_d;
  logic                          accepting_q, accepting_d;
  logic [CNT_W-1:0]              idx_q, idx_d;
  logic [CNT_W-1:0]              k_q, k_d;
  logic [ID_BITS-1:0]            cand_q, cand_d;
  logic [ID_BITS-1:0]            tries_q, tries_d;
  logic [TIME_BITS-1:0]          time_q, time_d;
  logic [dtq_pkg::CANCEL_W-1:0]  cid_q, cid_d;
  logic                          found_q, found_d;
  logic                          pend_v_q, pend_v_d;
  logic [ID_BITS-1:0]            pend_id_q, pend_id_d;
  logic [dtq_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
  logic [dtq_pkg::OUT_ID_W-1:0]  res_id_q, res_id_d;
  logic                          out_valid_q, out_valid_d;
  logic [dtq_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [dtq_pkg::OUT_ID_W-1:0]  item_id_q, item_id_d;
  logic                          last_q, last_d;

  logic                          out_free;
  logic [CNT_W-1:0]              idx_m1;
  logic [CNT_W-1:0]              cmp_dst;
  logic                          ram_wr_en;
  logic [IDX_W-1:0]              ram_wr_addr;
  logic [ENT_W-1:0]              ram_wr_data;
  logic                          ram_rd_en;
  logic [IDX_W-1:0]              ram_rd_addr;
  logic [ENT_W-1:0]              ram_rd_data;
  logic [TIME_BITS-1:0]          rd_due;
  logic [ID_BITS-1:0]            rd_id;

  dtq_entry_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign rd_due = ram_rd_data[ENT_W-1:ID_BITS];
  assign rd_id  = ram_rd_data[ID_BITS-1:0];

  // The output register can take a new result this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign idx_m1     = idx_q - 1'b1;
  assign cmp_dst    = idx_q - k_q;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign item_id_o   = item_id_q;
  assign last_o      = last_q;

  // Sequencer: next state, memory port controls and results.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    next_id_d    = next_id_q;
    accepting_d  = accepting_q;
    idx_d        = idx_q;
    k_d          = k_q;
    cand_d       = cand_q;
    tries_d      = tries_q;
    time_d       = time_q;
    cid_d        = cid_q;
    found_d      = found_q;
    pend_v_d     = pend_v_q;
    pend_id_d    = pend_id_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    item_id_d    = item_id_q;
    last_d       = last_q;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = idx_q[IDX_W-1:0];
    ram_wr_data  = {due_time_i, cand_q};
    ram_rd_en    = 1'b0;
    ram_rd_addr  = idx_q[IDX_W-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          unique case (dtq_pkg::req_e'(req_type_i))
            dtq_pkg::REQ_ADD: begin
              if (!accepting_q) begin
                out_valid_d = 1'b1;
                status_d    = dtq_pkg::ST_NOT_ACCEPTING;
                item_id_d   = '0;
                last_d      = 1'b1;
              end else if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
                out_valid_d = 1'b1;
                status_d    = dtq_pkg::ST_FULL;
                item_id_d   = '0;
                last_d      = 1'b1;
              end else begin
                cand_d  = next_id_q;
                tries_d = '0;
                idx_d   = '0;
                time_d  = due_time_i;
                state_d = S_ID_RD;
              end
            end
            dtq_pkg::REQ_CANCEL: begin
              cid_d   = cancel_id_i;
              idx_d   = '0;
              found_d = 1'b0;
              state_d = S_CAN_RD;
            end
            dtq_pkg::REQ_TICK: begin
              if (!accepting_q) begin
                out_valid_d = 1'b1;
                status_d    = dtq_pkg::ST_NOT_ACCEPTING;
                item_id_d   = '0;
                last_d      = 1'b1;
              end else begin
                time_d   = now_time_i;
                idx_d    = '0;
                pend_v_d = 1'b0;
                state_d  = S_TICK_RD;
              end
            end
            dtq_pkg::REQ_STOP: begin
              accepting_d = 1'b0;
              out_valid_d = 1'b1;
              status_d    = dtq_pkg::ST_STOPPED;
              item_id_d   = '0;
              last_d      = 1'b1;
            end
            default: ;
          endcase
        end
      end

      // Free id search: scan the entries for the candidate id; on a match, try the next id.
      S_ID_RD: begin
        if (idx_q == cnt_q) begin
          next_id_d = cand_q + 1'b1;
          idx_d     = cnt_q;
          state_d   = S_INS_RD;
        end else begin
          ram_rd_en = 1'b1;
          state_d   = S_ID_CHK;
        end
      end

      S_ID_CHK: begin
        if (rd_id == cand_q) begin
          if (tries_q == {ID_BITS{1'b1}}) begin
            res_status_d = dtq_pkg::ST_FULL;
            res_id_d     = '0;
            state_d      = S_FIN;
          end else begin
            cand_d  = cand_q + 1'b1;
            tries_d = tries_q + 1'b1;
            idx_d   = '0;
            state_d = S_ID_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_ID_RD;
        end
      end

      // Ordered insert: walk down from the tail, moving later entries up.
      S_INS_RD: begin
        if (idx_q == '0) begin
          ram_wr_en    = 1'b1;
          ram_wr_data  = {time_q, cand_q};
          cnt_d        = cnt_q + 1'b1;
          res_status_d = dtq_pkg::ST_ADDED;
          res_id_d     = dtq_pkg::OUT_ID_W'(cand_q);
          state_d      = S_FIN;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_m1[IDX_W-1:0];
          state_d     = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        ram_wr_en = 1'b1;
        if (time_q < rd_due) begin
          ram_wr_data = ram_rd_data;
          idx_d       = idx_m1;
          state_d     = S_INS_RD;
        end else begin
          ram_wr_data  = {time_q, cand_q};
          cnt_d        = cnt_q + 1'b1;
          res_status_d = dtq_pkg::ST_ADDED;
          res_id_d     = dtq_pkg::OUT_ID_W'(cand_q);
          state_d      = S_FIN;
        end
      end

      // Cancel: find the id, then move every later entry down by one.
      S_CAN_RD: begin
        if (idx_q == cnt_q) begin
          res_status_d = found_q ? dtq_pkg::ST_CANCELLED : dtq_pkg::ST_CANCEL_FAILED;
          res_id_d     = cid_q;
          if (found_q) begin
            cnt_d = cnt_q - 1'b1;
          end
          state_d = S_FIN;
        end else begin
          ram_rd_en = 1'b1;
          state_d   = S_CAN_CHK;
        end
      end

      S_CAN_CHK: begin
        if (found_q) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = idx_m1[IDX_W-1:0];
          ram_wr_data = ram_rd_data;
        end else if (CMP_W'(rd_id) == CMP_W'(cid_q)) begin
          found_d = 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_CAN_RD;
      end

      // Tick: fire due entries from the head. Each fired id is held back
      // one step so that the final one can carry the last flag.
      S_TICK_RD: begin
        if (idx_q == cnt_q || idx_q == CNT_W'(FIRE_LIMIT)) begin
          state_d = S_TICK_END;
        end else begin
          ram_rd_en = 1'b1;
          state_d   = S_TICK_CHK;
        end
      end

      S_TICK_CHK: begin
        if (rd_due <= time_q) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              status_d    = dtq_pkg::ST_FIRED;
              item_id_d   = dtq_pkg::OUT_ID_W'(pend_id_q);
              last_d      = 1'b0;
            end
            pend_v_d  = 1'b1;
            pend_id_d = rd_id;
            idx_d     = idx_q + 1'b1;
            state_d   = S_TICK_RD;
          end
        end else begin
          state_d = S_TICK_END;
        end
      end

      S_TICK_END: begin
        if (!pend_v_q) begin
          res_status_d = dtq_pkg::ST_NONE_DUE;
          res_id_d     = '0;
          state_d      = S_FIN;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = dtq_pkg::ST_FIRED;
          item_id_d   = dtq_pkg::OUT_ID_W'(pend_id_q);
          last_d      = 1'b1;
          k_d         = idx_q;
          state_d     = S_CMP_RD;
        end
      end

      // Close the gap left by the fired entries at the head.
      S_CMP_RD: begin
        if (idx_q == cnt_q) begin
          cnt_d   = cnt_q - k_q;
          state_d = S_IDLE;
        end else begin
          ram_rd_en = 1'b1;
          state_d   = S_CMP_WR;
        end
      end

      S_CMP_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = cmp_dst[IDX_W-1:0];
        ram_wr_data = ram_rd_data;
        idx_d       = idx_q + 1'b1;
        state_d     = S_CMP_RD;
      end

      // Single final result, sent once the output register is free.
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          item_id_d   = res_id_q;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      next_id_q    <= '0;
      accepting_q  <= 1'b1;
      idx_q        <= '0;
      k_q          <= '0;
      cand_q       <= '0;
      tries_q      <= '0;
      time_q       <= '0;
      cid_q        <= '0;
      found_q      <= 1'b0;
      pend_v_q     <= 1'b0;
      pend_id_q    <= '0;
      res_status_q <= '0;
      res_id_q     <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= '0;
      item_id_q    <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      next_id_q    <= next_id_d;
      accepting_q  <= accepting_d;
      idx_q        <= idx_d;
      k_q          <= k_d;
      cand_q       <= cand_d;
      tries_q      <= tries_d;
      time_q       <= time_d;
      cid_q        <= cid_d;
      found_q      <= found_d;
      pend_v_q     <= pend_v_d;
      pend_id_q    <= pend_id_d;
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      item_id_q    <= item_id_d;
      last_q       <= last_d;
    end
  end

endmodule

`default_nettype wire
